### rtl/pdcf_pkg.sv
// ----------------------------------------------------------------------------
// Poisson disc candidate filter package
// Shared constants, codes and types for the candidate filter.
// ----------------------------------------------------------------------------
package pdcf_pkg;

  localparam int unsigned GRID_DIM     = 64;
  localparam int unsigned GRID_BITS    = $clog2(GRID_DIM);
  localparam int unsigned CELLS        = GRID_DIM * GRID_DIM;
  localparam int unsigned CELL_BITS    = 2 * GRID_BITS;
  localparam int unsigned MAX_POINTS   = 4096;
  localparam int unsigned PT_BITS      = $clog2(MAX_POINTS);
  localparam int unsigned COUNT_BITS   = PT_BITS + 1;
  localparam int unsigned COORD_BITS   = 16;
  localparam int unsigned DIV_CNT_BITS = $clog2(COORD_BITS);
  localparam int unsigned GRID_WIDTH   = PT_BITS + 1;
  localparam int unsigned STORE_WIDTH  = 2 * COORD_BITS;
  localparam int unsigned SQ_BITS      = 2 * COORD_BITS;
  localparam int unsigned CFG_BITS     = 16;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned STATUS_BITS  = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LEFT_EDGE   = 3'd0,
    REG_TOP_EDGE    = 3'd1,
    REG_RIGHT_EDGE  = 3'd2,
    REG_BOTTOM_EDGE = 3'd3,
    REG_MIN_DIST    = 3'd4,
    REG_CELL_SIZE   = 3'd5
  } cfg_reg_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK      = 3'd0,
    ST_OUTSIDE = 3'd1,
    ST_CLOSE   = 3'd2,
    ST_FULL    = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIVX,
    S_DIVY,
    S_LIM,
    S_SCAN_RD,
    S_GRID_WAIT,
    S_STORE_WAIT,
    S_MULX,
    S_MULY,
    S_CMP,
    S_INSERT,
    S_DONE
  } state_t;

endpackage

### rtl/pdcf_in_if.sv
// ----------------------------------------------------------------------------
// Candidate request channel
// Valid/ready channel carrying one command and candidate point.
// ----------------------------------------------------------------------------
interface pdcf_in_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [pdcf_pkg::COORD_BITS-1:0] cand_x;
  logic [pdcf_pkg::COORD_BITS-1:0] cand_y;

  modport source (output valid, command, cand_x, cand_y, input ready);
  modport sink   (input valid, command, cand_x, cand_y, output ready);
endinterface

### rtl/pdcf_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the verdict on one request.
// ----------------------------------------------------------------------------
interface pdcf_out_if;
  logic                             valid;
  logic                             ready;
  logic                             accepted;
  logic [pdcf_pkg::STATUS_BITS-1:0] status;
  logic [pdcf_pkg::PT_BITS-1:0]     point_index;
  logic [pdcf_pkg::COUNT_BITS-1:0]  point_total;

  modport source (output valid, accepted, status, point_index, point_total, input ready);
  modport sink   (input valid, accepted, status, point_index, point_total, output ready);
endinterface

### rtl/pdcf_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface pdcf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pdcf_pkg::CFG_IDX_BITS-1:0] index;
  logic [pdcf_pkg::CFG_BITS-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/pdcf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pdcf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/pdcf_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdcf_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [pdcf_pkg::COORD_BITS-1:0] dividend,
  input  logic [pdcf_pkg::COORD_BITS-1:0] divisor,
  output logic                            done,
  output logic [pdcf_pkg::COORD_BITS-1:0] quotient
);

  localparam int unsigned W = pdcf_pkg::COORD_BITS;
  localparam int unsigned CW = pdcf_pkg::DIV_CNT_BITS;

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    shifted;
  logic [W:0]    trial;

  always_comb begin
    shifted  = {rem_r, quo_r[W-1]};
    trial    = shifted - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      // The top bit of the trial difference is the borrow.
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/poisson_disc_candidate_filter_top.sv
// ----------------------------------------------------------------------------
// Poisson disc candidate filter
// Region test, grid cell division, neighbourhood distance scan and insertion.
// ----------------------------------------------------------------------------
// An outside candidate goes straight to the report; an inside one runs the
// two 16-step divisions and the limit square, then scans up to 25 cells
// through the grid RAM, point RAM and the one shared 16x16 multiplier, then
// inserts and reports. One request at a time.
// A clear request sweeps all 4096 cells of the grid, one cell per cycle.
// After reset the same sweep runs before the first request is taken.
module poisson_disc_candidate_filter_top (
  input  logic       clk,
  input  logic       rst_n,
  pdcf_in_if.sink    in_ch,
  pdcf_out_if.source out_ch,
  pdcf_cfg_if.sink   cfg_ch
);

  localparam int unsigned CB = pdcf_pkg::COORD_BITS;
  localparam int unsigned GB = pdcf_pkg::GRID_BITS;
  localparam int unsigned PB = pdcf_pkg::PT_BITS;
  localparam int unsigned NB = pdcf_pkg::COUNT_BITS;
  localparam int unsigned QB = pdcf_pkg::SQ_BITS;
  localparam logic [GB-1:0] GMAX = GB'(pdcf_pkg::GRID_DIM - 1);

  pdcf_pkg::state_t state_r, state_nxt;

  logic [CB-1:0] left_r, top_r, right_r, bottom_r, mind_r, csize_r;

  logic [CB-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [GB-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [GB-1:0] gx_r, gx_nxt, gy_r, gy_nxt;
  logic [GB-1:0] x0_r, x0_nxt, x1_r, x1_nxt, y0_r, y0_nxt, y1_r, y1_nxt;
  logic [QB-1:0] lim_r, lim_nxt, sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic [pdcf_pkg::STORE_WIDTH-1:0] pt_r, pt_nxt;
  logic [NB-1:0] count_r, count_nxt;
  logic [pdcf_pkg::CELL_BITS-1:0] clr_r, clr_nxt;
  logic          clr_result_r, clr_result_nxt;
  pdcf_pkg::status_t res_status_r, res_status_nxt;
  logic [PB-1:0] res_idx_r, res_idx_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_acc_r, out_acc_nxt;
  pdcf_pkg::status_t out_status_r, out_status_nxt;
  logic [PB-1:0] out_idx_r, out_idx_nxt;
  logic [NB-1:0] out_total_r, out_total_nxt;

  logic          div_start, div_done;
  logic [CB-1:0] div_dividend, div_divisor, div_q;
  logic [GB-1:0] q_clamped;

  logic          grid_we;
  logic [pdcf_pkg::CELL_BITS-1:0] grid_waddr, grid_raddr;
  logic [pdcf_pkg::GRID_WIDTH-1:0] grid_wdata, grid_rdata;
  logic          store_we;
  logic [pdcf_pkg::STORE_WIDTH-1:0] store_rdata;

  logic [CB-1:0] mul_a;
  logic [QB-1:0] product;
  logic [CB-1:0] dx, dy;
  logic [QB:0]   dist_sum;
  logic          in_acc, in_region, last_cell;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      right_r  <= CB'(65535);
      bottom_r <= CB'(65535);
      mind_r   <= CB'(1448);
      csize_r  <= CB'(1024);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        pdcf_pkg::REG_LEFT_EDGE:   left_r   <= cfg_ch.data;
        pdcf_pkg::REG_TOP_EDGE:    top_r    <= cfg_ch.data;
        pdcf_pkg::REG_RIGHT_EDGE:  right_r  <= cfg_ch.data;
        pdcf_pkg::REG_BOTTOM_EDGE: bottom_r <= cfg_ch.data;
        pdcf_pkg::REG_MIN_DIST:    mind_r   <= cfg_ch.data;
        pdcf_pkg::REG_CELL_SIZE:   csize_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  pdcf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  pdcf_ram #(
    .WIDTH (pdcf_pkg::GRID_WIDTH),
    .DEPTH (pdcf_pkg::CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (grid_we),
    .waddr (grid_waddr),
    .wdata (grid_wdata),
    .raddr (grid_raddr),
    .rdata (grid_rdata)
  );

  pdcf_ram #(
    .WIDTH (pdcf_pkg::STORE_WIDTH),
    .DEPTH (pdcf_pkg::MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count_r[PB-1:0]),
    .wdata ({y_r, x_r}),
    .raddr (grid_rdata[PB-1:0]),
    .rdata (store_rdata)
  );

  assign in_ch.ready = (state_r == pdcf_pkg::S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_region   = (in_ch.cand_x >= left_r) && (in_ch.cand_x <= right_r) &&
                       (in_ch.cand_y >= top_r) && (in_ch.cand_y <= bottom_r);
  assign div_divisor = (csize_r == '0) ? CB'(1) : csize_r;
  assign q_clamped   = (div_q > CB'(pdcf_pkg::GRID_DIM - 1)) ? GMAX : div_q[GB-1:0];
  assign grid_raddr  = {gx_r, gy_r};
  assign last_cell   = (gx_r == x1_r) && (gy_r == y1_r);

  assign dx       = (pt_r[CB-1:0] > x_r) ? pt_r[CB-1:0] - x_r : x_r - pt_r[CB-1:0];
  assign dy       = (pt_r[2*CB-1:CB] > y_r) ? pt_r[2*CB-1:CB] - y_r : y_r - pt_r[2*CB-1:CB];
  assign dist_sum = {1'b0, sqx_r} + {1'b0, sqy_r};

  // The single multiplier squares the distance limit and then each axis difference.
  always_comb begin
    unique case (state_r)
      pdcf_pkg::S_MULX: mul_a = dx;
      pdcf_pkg::S_MULY: mul_a = dy;
      default:          mul_a = mind_r;
    endcase
    product = QB'(mul_a) * QB'(mul_a);
  end

  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    gx_nxt         = gx_r;
    gy_nxt         = gy_r;
    x0_nxt         = x0_r;
    x1_nxt         = x1_r;
    y0_nxt         = y0_r;
    y1_nxt         = y1_r;
    lim_nxt        = lim_r;
    sqx_nxt        = sqx_r;
    sqy_nxt        = sqy_r;
    pt_nxt         = pt_r;
    count_nxt      = count_r;
    clr_nxt        = clr_r;
    clr_result_nxt = clr_result_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_acc_nxt    = out_acc_r;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_total_nxt  = out_total_r;
    div_start      = 1'b0;
    div_dividend   = in_ch.cand_x - left_r;
    grid_we        = 1'b0;
    grid_waddr     = clr_r;
    grid_wdata     = '0;
    store_we       = 1'b0;

    unique case (state_r)
      pdcf_pkg::S_CLEAR: begin
        grid_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = clr_result_r ? pdcf_pkg::S_DONE : pdcf_pkg::S_IDLE;
        end
      end
      pdcf_pkg::S_IDLE: begin
        if (in_acc) begin
          x_nxt       = in_ch.cand_x;
          y_nxt       = in_ch.cand_y;
          res_idx_nxt = '0;
          if (in_ch.command) begin
            count_nxt      = '0;
            clr_nxt        = '0;
            clr_result_nxt = 1'b1;
            res_status_nxt = pdcf_pkg::ST_CLEARED;
            state_nxt      = pdcf_pkg::S_CLEAR;
          end else if (!in_region) begin
            res_status_nxt = pdcf_pkg::ST_OUTSIDE;
            state_nxt      = pdcf_pkg::S_DONE;
          end else begin
            div_start = 1'b1;
            state_nxt = pdcf_pkg::S_DIVX;
          end
        end
      end
      pdcf_pkg::S_DIVX: begin
        div_dividend = y_r - top_r;
        if (div_done) begin
          cx_nxt    = q_clamped;
          div_start = 1'b1;
          state_nxt = pdcf_pkg::S_DIVY;
        end
      end
      pdcf_pkg::S_DIVY: begin
        if (div_done) begin
          cy_nxt    = q_clamped;
          state_nxt = pdcf_pkg::S_LIM;
        end
      end
      pdcf_pkg::S_LIM: begin
        lim_nxt   = product;
        x0_nxt    = (cx_r >= GB'(2)) ? cx_r - GB'(2) : '0;
        y0_nxt    = (cy_r >= GB'(2)) ? cy_r - GB'(2) : '0;
        x1_nxt    = (cx_r > GMAX - GB'(2)) ? GMAX : cx_r + GB'(2);
        y1_nxt    = (cy_r > GMAX - GB'(2)) ? GMAX : cy_r + GB'(2);
        gx_nxt    = x0_nxt;
        gy_nxt    = y0_nxt;
        state_nxt = pdcf_pkg::S_SCAN_RD;
      end
      pdcf_pkg::S_SCAN_RD: begin
        state_nxt = pdcf_pkg::S_GRID_WAIT;
      end
      pdcf_pkg::S_GRID_WAIT: begin
        if (grid_rdata[PB]) begin
          state_nxt = pdcf_pkg::S_STORE_WAIT;
        end else if (last_cell) begin
          state_nxt = pdcf_pkg::S_INSERT;
        end else begin
          if (gy_r == y1_r) begin
            gy_nxt = y0_r;
            gx_nxt = gx_r + 1'b1;
          end else begin
            gy_nxt = gy_r + 1'b1;
          end
          state_nxt = pdcf_pkg::S_SCAN_RD;
        end
      end
      pdcf_pkg::S_STORE_WAIT: begin
        pt_nxt    = store_rdata;
        state_nxt = pdcf_pkg::S_MULX;
      end
      pdcf_pkg::S_MULX: begin
        sqx_nxt   = product;
        state_nxt = pdcf_pkg::S_MULY;
      end
      pdcf_pkg::S_MULY: begin
        sqy_nxt   = product;
        state_nxt = pdcf_pkg::S_CMP;
      end
      pdcf_pkg::S_CMP: begin
        if (dist_sum < {1'b0, lim_r}) begin
          res_status_nxt = pdcf_pkg::ST_CLOSE;
          state_nxt      = pdcf_pkg::S_DONE;
        end else if (last_cell) begin
          state_nxt = pdcf_pkg::S_INSERT;
        end else begin
          if (gy_r == y1_r) begin
            gy_nxt = y0_r;
            gx_nxt = gx_r + 1'b1;
          end else begin
            gy_nxt = gy_r + 1'b1;
          end
          state_nxt = pdcf_pkg::S_SCAN_RD;
        end
      end
      pdcf_pkg::S_INSERT: begin
        if (count_r >= NB'(pdcf_pkg::MAX_POINTS)) begin
          res_status_nxt = pdcf_pkg::ST_FULL;
        end else begin
          grid_we        = 1'b1;
          grid_waddr     = {cx_r, cy_r};
          grid_wdata     = {1'b1, count_r[PB-1:0]};
          store_we       = 1'b1;
          res_idx_nxt    = count_r[PB-1:0];
          res_status_nxt = pdcf_pkg::ST_OK;
          count_nxt      = count_r + 1'b1;
        end
        state_nxt = pdcf_pkg::S_DONE;
      end
      pdcf_pkg::S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_acc_nxt    = (res_status_r == pdcf_pkg::ST_OK);
          out_status_nxt = res_status_r;
          out_idx_nxt    = res_idx_r;
          out_total_nxt  = count_r;
          clr_result_nxt = 1'b0;
          state_nxt      = pdcf_pkg::S_IDLE;
        end
      end
      default: state_nxt = pdcf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pdcf_pkg::S_CLEAR;
      clr_r        <= '0;
      clr_result_r <= 1'b0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      clr_result_r <= clr_result_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    cx_r         <= cx_nxt;
    cy_r         <= cy_nxt;
    gx_r         <= gx_nxt;
    gy_r         <= gy_nxt;
    x0_r         <= x0_nxt;
    x1_r         <= x1_nxt;
    y0_r         <= y0_nxt;
    y1_r         <= y1_nxt;
    lim_r        <= lim_nxt;
    sqx_r        <= sqx_nxt;
    sqy_r        <= sqy_nxt;
    pt_r         <= pt_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    out_acc_r    <= out_acc_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_total_r  <= out_total_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.accepted    = out_acc_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.point_index = out_idx_r;
  assign out_ch.point_total = out_total_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NB'(pdcf_pkg::MAX_POINTS))
    else $error("point count exceeds the store depth");

  a_accept_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_acc_r |-> out_status_r == pdcf_pkg::ST_OK)
    else $error("accepted flag set without an accepted status");

  a_valid_write: assert property (@(posedge clk) disable iff (!rst_n)
    grid_we && grid_wdata[PB] |-> state_r == pdcf_pkg::S_INSERT && store_we)
    else $error("cell marked outside an insertion");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    store_we |=> count_r == $past(count_r) + 1'b1)
    else $error("point count did not advance on insertion");

  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pdcf_pkg::S_CLEAR |-> count_r == '0)
    else $error("point count not zero during the grid sweep");

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// Poisson disc candidate filter testbench
// Drives candidate and clear requests through the valid/ready channels, keeps
// its own grid and point store to predict every verdict, and checks each
// result in order. Covers region limits, grid edges, close rejections, shared
// cells, clears and several register settings under back-pressure.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                 accepted;
    pdcf_pkg::status_t    status;
    logic [11:0]          point_index;
    logic [12:0]          point_total;
  } verdict_t;

  typedef enum int {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    bit                 clear_cmd;
    logic [15:0]        x;
    logic [15:0]        y;
    bit                 typed;
    verdict_t           verdict;
    pdcf_pkg::cfg_reg_t reg_idx;
    logic [15:0]        data;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  pdcf_in_if  in_ch();
  pdcf_out_if out_ch();
  pdcf_cfg_if cfg_ch();

  poisson_disc_candidate_filter_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // Shadow of the block's registers and storage.
  logic [15:0] left_q, top_q, right_q, bottom_q, dist_q, cell_q;
  bit          cell_used [pdcf_pkg::CELLS];
  logic [11:0] cell_point [pdcf_pkg::CELLS];
  logic [15:0] pt_x [pdcf_pkg::MAX_POINTS];
  logic [15:0] pt_y [pdcf_pkg::MAX_POINTS];
  int unsigned stored_pts;

  verdict_t verdict_q[$];
  int errors = 0;
  int n_ok = 0, n_out = 0, n_close = 0, n_full = 0, n_clr = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;
  row_t rows[$];

  function automatic int unsigned cell_of(logic [15:0] v, logic [15:0] base);
    int unsigned cs;
    int unsigned c;
    cs = (cell_q == 0) ? 1 : cell_q;
    c = (int'(v) - int'(base)) / cs;
    return (c > pdcf_pkg::GRID_DIM - 1) ? pdcf_pkg::GRID_DIM - 1 : c;
  endfunction

  function automatic verdict_t judge_candidate(bit clear_cmd, logic [15:0] x, logic [15:0] y);
    verdict_t r;
    int unsigned cx, cy, gx0, gy0, gx1, gy1, c;
    longint unsigned lim, d, dx, dy;
    r = '0;
    r.status = pdcf_pkg::ST_OK;
    if (clear_cmd) begin
      foreach (cell_used[i]) cell_used[i] = 1'b0;
      stored_pts = 0;
      r.status = pdcf_pkg::ST_CLEARED;
    end else if (x < left_q || y < top_q || x > right_q || y > bottom_q) begin
      r.status = pdcf_pkg::ST_OUTSIDE;
    end else begin
      cx = cell_of(x, left_q);
      cy = cell_of(y, top_q);
      gx0 = (cx >= 2) ? cx - 2 : 0;
      gy0 = (cy >= 2) ? cy - 2 : 0;
      gx1 = (cx + 2 > pdcf_pkg::GRID_DIM - 1) ? pdcf_pkg::GRID_DIM - 1 : cx + 2;
      gy1 = (cy + 2 > pdcf_pkg::GRID_DIM - 1) ? pdcf_pkg::GRID_DIM - 1 : cy + 2;
      lim = longint'(dist_q) * longint'(dist_q);
      for (int unsigned gx = gx0; gx <= gx1; gx++) begin
        for (int unsigned gy = gy0; gy <= gy1; gy++) begin
          c = gx * pdcf_pkg::GRID_DIM + gy;
          if (cell_used[c]) begin
            dx = (pt_x[cell_point[c]] > x) ? pt_x[cell_point[c]] - x : x - pt_x[cell_point[c]];
            dy = (pt_y[cell_point[c]] > y) ? pt_y[cell_point[c]] - y : y - pt_y[cell_point[c]];
            d = dx * dx + dy * dy;
            if (d < lim) r.status = pdcf_pkg::ST_CLOSE;
          end
        end
      end
      if (r.status == pdcf_pkg::ST_OK && stored_pts >= pdcf_pkg::MAX_POINTS) begin
        r.status = pdcf_pkg::ST_FULL;
      end
      if (r.status == pdcf_pkg::ST_OK) begin
        c = cx * pdcf_pkg::GRID_DIM + cy;
        r.point_index = stored_pts[11:0];
        pt_x[stored_pts] = x;
        pt_y[stored_pts] = y;
        cell_point[c] = stored_pts[11:0];
        cell_used[c] = 1'b1;
        stored_pts++;
      end
    end
    r.accepted = (r.status == pdcf_pkg::ST_OK);
    r.point_total = stored_pts[12:0];
    return r;
  endfunction

  // Called at a falling edge; returns at a falling edge after acceptance and any random idle gap.
  task automatic send_request(bit clear_cmd, logic [15:0] x, logic [15:0] y,
                              bit typed, verdict_t typed_v);
    verdict_t v;
    int gap;
    in_ch.valid   <= 1'b1;
    in_ch.command <= clear_cmd;
    in_ch.cand_x  <= x;
    in_ch.cand_y  <= y;
    do @(posedge clk); while (!in_ch.ready);
    v = judge_candidate(clear_cmd, x, y);
    verdict_q.push_back(typed ? typed_v : v);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 10);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    wait (verdict_q.size() == 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(pdcf_pkg::cfg_reg_t idx, logic [15:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      pdcf_pkg::REG_LEFT_EDGE:   left_q = data;
      pdcf_pkg::REG_TOP_EDGE:    top_q = data;
      pdcf_pkg::REG_RIGHT_EDGE:  right_q = data;
      pdcf_pkg::REG_BOTTOM_EDGE: bottom_q = data;
      pdcf_pkg::REG_MIN_DIST:    dist_q = data;
      pdcf_pkg::REG_CELL_SIZE:   cell_q = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic void add_req(bit c, logic [15:0] x, logic [15:0] y, bit typed = 0,
                                  logic acc = 0, pdcf_pkg::status_t st = pdcf_pkg::ST_OK,
                                  int idx = 0, int tot = 0);
    row_t r;
    r.kind = ROW_REQ; r.clear_cmd = c; r.x = x; r.y = y; r.typed = typed;
    r.verdict = '{acc, st, idx[11:0], tot[12:0]};
    r.reg_idx = pdcf_pkg::REG_LEFT_EDGE; r.data = '0;
    rows.push_back(r);
  endfunction

  function automatic void add_cfg(pdcf_pkg::cfg_reg_t idx, logic [15:0] data);
    row_t r;
    r = '{ROW_CFG, 1'b0, '0, '0, 1'b0, '0, idx, data};
    rows.push_back(r);
  endfunction

  // Result checker.
  always @(posedge clk) begin
    verdict_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.accepted, pdcf_pkg::status_t'(out_ch.status), out_ch.point_index,
              out_ch.point_total};
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = verdict_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
        end
        case (want.status)
          pdcf_pkg::ST_OK:      n_ok++;
          pdcf_pkg::ST_OUTSIDE: n_out++;
          pdcf_pkg::ST_CLOSE:   n_close++;
          pdcf_pkg::ST_FULL:    n_full++;
          default:              n_clr++;
        endcase
      end
    end
  end

  // Result receiver: stalls on its own changing pattern, plus one long hold.
  initial begin
    int mode;
    out_ch.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat (64) begin
        @(negedge clk);
        if (hold_req) begin
          out_ch.ready <= 1'b0;
          repeat (3000) @(negedge clk);
          hold_req = 1'b0;
        end
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= $urandom_range(0, 1);
          2:       out_ch.ready <= ($urandom_range(0, 4) == 0);
          default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    #200ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned cs, span_x, span_y, mx, my;
    logic [15:0] x, y;
    in_ch.valid = 1'b0; in_ch.command = 1'b0; in_ch.cand_x = '0; in_ch.cand_y = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = pdcf_pkg::REG_LEFT_EDGE; cfg_ch.data = '0;
    left_q = 0; top_q = 0; right_q = 16'hFFFF; bottom_q = 16'hFFFF;
    dist_q = 1448; cell_q = 1024; stored_pts = 0;
    foreach (cell_used[i]) cell_used[i] = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed requests under the reset settings, then edge settings.
    add_req(0, 0, 0, 1, 1, pdcf_pkg::ST_OK, 0, 1);
    add_req(0, 16'hFFFF, 16'hFFFF, 1, 1, pdcf_pkg::ST_OK, 1, 2);
    add_req(0, 1, 1, 1, 0, pdcf_pkg::ST_CLOSE, 0, 2);
    add_req(0, 1448, 0, 1, 1, pdcf_pkg::ST_OK, 2, 3);
    add_req(0, 1447, 1, 1, 0, pdcf_pkg::ST_CLOSE, 0, 3);
    add_req(0, 2000, 40000);
    add_req(1, 16'hFFFF, 16'hFFFF, 1, 0, pdcf_pkg::ST_CLEARED, 0, 0);
    add_req(0, 16'hAAAA, 16'h5555);
    add_req(0, 16'h5555, 16'hAAAA);
    add_cfg(pdcf_pkg::REG_LEFT_EDGE, 100);
    add_cfg(pdcf_pkg::REG_TOP_EDGE, 200);
    add_cfg(pdcf_pkg::REG_RIGHT_EDGE, 60000);
    add_cfg(pdcf_pkg::REG_BOTTOM_EDGE, 50000);
    add_req(0, 99, 300);
    add_req(0, 100, 200);
    add_req(0, 60001, 300);
    add_req(0, 300, 50001);
    add_req(0, 60000, 50000);
    add_cfg(pdcf_pkg::REG_LEFT_EDGE, 5000);
    add_cfg(pdcf_pkg::REG_RIGHT_EDGE, 4000);
    add_req(0, 4500, 300);
    add_cfg(pdcf_pkg::REG_LEFT_EDGE, 0);
    add_cfg(pdcf_pkg::REG_RIGHT_EDGE, 16'hFFFF);
    add_cfg(pdcf_pkg::REG_TOP_EDGE, 0);
    add_cfg(pdcf_pkg::REG_BOTTOM_EDGE, 16'hFFFF);
    add_cfg(pdcf_pkg::REG_MIN_DIST, 0);
    add_cfg(pdcf_pkg::REG_CELL_SIZE, 0);
    add_req(0, 10, 10);
    add_req(0, 10, 10);
    add_cfg(pdcf_pkg::REG_MIN_DIST, 16'hFFFF);
    add_cfg(pdcf_pkg::REG_CELL_SIZE, 16'hFFFF);
    add_req(0, 0, 0);
    add_req(0, 16'hFFFF, 16'hFFFF);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(rows[i].reg_idx, rows[i].data);
      end else begin
        send_request(rows[i].clear_cmd, rows[i].x, rows[i].y, rows[i].typed,
                     rows[i].verdict);
      end
    end

    // Random phases: clustered candidates in a random region, some noise.
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      case (ph)
        0:       cs = 1024;
        1:       cs = 1;
        2:       cs = 16'hFFFF;
        default: cs = $urandom_range(1, 3000);
      endcase
      mx = $urandom_range(3, 70);
      my = $urandom_range(3, 70);
      span_x = (cs * mx > 65535) ? 65535 : cs * mx;
      span_y = (cs * my > 65535) ? 65535 : cs * my;
      write_reg(pdcf_pkg::REG_CELL_SIZE, cs[15:0]);
      write_reg(pdcf_pkg::REG_MIN_DIST, (ph == 1) ? 16'd1 : (ph == 2) ? 16'hFFFF :
                16'((cs * 1414) / 1000 + $urandom_range(0, 200)));
      write_reg(pdcf_pkg::REG_LEFT_EDGE, 16'($urandom_range(0, 65535 - span_x)));
      write_reg(pdcf_pkg::REG_TOP_EDGE, 16'($urandom_range(0, 65535 - span_y)));
      write_reg(pdcf_pkg::REG_RIGHT_EDGE, 16'(left_q + span_x));
      write_reg(pdcf_pkg::REG_BOTTOM_EDGE, 16'(top_q + span_y));
      send_request(1, 16'($urandom), 16'($urandom), 0, '0);
      if (ph == 3) hold_req = 1'b1;
      repeat (130) begin
        case ($urandom_range(0, 99))
          0:       send_request(1, 16'($urandom), 16'($urandom), 0, '0);
          1, 2, 3, 4, 5, 6, 7, 8, 9, 10:
                   send_request(0, 16'($urandom), 16'($urandom), 0, '0);
          default: begin
            x = 16'(left_q + $urandom_range(0, span_x));
            y = 16'(top_q + $urandom_range(0, span_y));
            send_request(0, x, y, 0, '0);
          end
        endcase
      end
    end

    drain();
    repeat (200) @(negedge clk);
    $display("Covered %0d accepted, %0d outside, %0d too close, %0d store full,",
             n_ok, n_out, n_close, n_full);
    $display("and %0d clears across ten random register settings.", n_clr);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

### files.f
rtl/pdcf_pkg.sv
rtl/pdcf_in_if.sv
rtl/pdcf_out_if.sv
rtl/pdcf_cfg_if.sv
rtl/pdcf_ram.sv
rtl/pdcf_div.sv
rtl/poisson_disc_candidate_filter_top.sv
bench/tb.sv
